### rtl/pcc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcc_pkg: shared types and constants for the polar/Cartesian converter
// Holds the opcode and sideband types, the CORDIC arctangent table, the
// fixed-point formats and the gain correction constant.
// ----------------------------------------------------------------------------
package pcc_pkg;

    // Fraction bits carried on x and y inside the rotation chain.
    localparam int GUARD = 16;
    // Angle accumulator width: a 32-bit binary angle with two bits of headroom.
    localparam int ZW = 34;
    // Converged CORDIC gain correction, 0.6072529350 in Q30.
    localparam logic [29:0] GAIN_Q30 = 30'd652032874;

    // atan(2^-i) in units of 2^32 per turn, rounded.
    localparam logic [31:0] ATAN_TABLE [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef enum logic {
        OP_TO_CART  = 1'b0,
        OP_TO_POLAR = 1'b1
    } pcc_op_t;

    // Control that rides along with each request through the pipeline.
    typedef struct packed {
        logic    valid;
        pcc_op_t opcode;
        logic    origin;
    } pcc_side_t;

endpackage
`default_nettype wire

### rtl/pcc_prep.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcc_prep: request setup ahead of the rotation chain
// Stage one forms radius times gain; stage two folds the angle into the
// right half plane and loads the initial x, y and angle accumulator.
// ----------------------------------------------------------------------------
module pcc_prep #(
    parameter int DW = 16,
    parameter int XW = 34
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      en,
    input  wire logic                      in_valid,
    input  wire pcc_pkg::pcc_op_t          in_opcode,
    input  wire logic signed [DW-1:0]      in_a,
    input  wire logic signed [DW-1:0]      in_b,
    output pcc_pkg::pcc_side_t             out_side,
    output logic signed [XW-1:0]           out_x,
    output logic signed [XW-1:0]           out_y,
    output logic signed [pcc_pkg::ZW-1:0]  out_z
);
    import pcc_pkg::*;

    localparam int SH = 32 - DW;
    localparam logic signed [ZW-1:0] QUARTER = ZW'(64'sd1 <<< 30);
    localparam logic signed [ZW-1:0] HALF    = ZW'(64'sd1 <<< 31);

    logic                    s1_valid_reg;
    pcc_op_t                 s1_op_reg;
    logic signed [DW-1:0]    s1_a_reg;
    logic signed [DW-1:0]    s1_b_reg;
    logic signed [DW+30:0]   s1_prod_reg;
    logic signed [DW+30:0]   prod_next;

    pcc_side_t               side_reg, side_next;
    logic signed [XW-1:0]    x_reg, x_next;
    logic signed [XW-1:0]    y_reg, y_next;
    logic signed [ZW-1:0]    z_reg, z_next;

    logic signed [XW-1:0]    x0;
    logic signed [XW-1:0]    xa;
    logic signed [XW-1:0]    ya;
    logic signed [31:0]      za32;
    logic signed [ZW-1:0]    zs;

    assign prod_next = in_b * $signed({1'b0, GAIN_Q30});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_op_reg   <= in_opcode;
            s1_a_reg    <= in_a;
            s1_b_reg    <= in_b;
            s1_prod_reg <= prod_next;
        end
    end

    assign x0   = XW'(s1_prod_reg >>> (30 - GUARD));
    assign xa   = XW'(s1_a_reg) <<< GUARD;
    assign ya   = XW'(s1_b_reg) <<< GUARD;
    assign za32 = 32'(s1_a_reg) <<< SH;
    assign zs   = ZW'(za32);

    always_comb begin
        side_next = '{valid: s1_valid_reg, opcode: s1_op_reg, origin: 1'b0};
        x_next    = x0;
        y_next    = '0;
        z_next    = zs;
        unique case (s1_op_reg)
            OP_TO_CART: begin
                // Angles beyond a quarter turn are turned by half a turn.
                priority if (zs > QUARTER) begin
                    z_next = zs - HALF;
                    x_next = -x0;
                end else if (zs < -QUARTER) begin
                    z_next = zs + HALF;
                    x_next = -x0;
                end else begin
                    z_next = zs;
                    x_next = x0;
                end
            end
            OP_TO_POLAR: begin
                side_next.origin = (s1_a_reg == '0) && (s1_b_reg == '0);
                if (s1_a_reg[DW-1]) begin
                    x_next = -xa;
                    y_next = -ya;
                    z_next = HALF;
                end else begin
                    x_next = xa;
                    y_next = ya;
                    z_next = '0;
                end
            end
            default: begin
                x_next = x0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg <= '0;
        end else if (en) begin
            side_reg <= side_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign out_side = side_reg;
    assign out_x    = x_reg;
    assign out_y    = y_reg;
    assign out_z    = z_reg;

    // After folding, the residual angle of a rotation stays within a quarter turn.
    a_fold_range: assert property (@(posedge aclk) disable iff (!aresetn)
        side_reg.valid && (side_reg.opcode == OP_TO_CART)
        |-> (z_reg <= QUARTER) && (z_reg >= -QUARTER))
        else $error("pcc_prep: folded angle outside a quarter turn");

endmodule
`default_nettype wire

### rtl/pcc_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcc_cell: one CORDIC micro-rotation
// Turns the vector by atan(2^-STAGE) toward the residual angle (rotation)
// or toward the x axis (vectoring) and registers the result.
// ----------------------------------------------------------------------------
module pcc_cell #(
    parameter int XW    = 34,
    parameter int STAGE = 0
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      en,
    input  wire pcc_pkg::pcc_side_t        side_in,
    input  wire logic signed [XW-1:0]      x_in,
    input  wire logic signed [XW-1:0]      y_in,
    input  wire logic signed [pcc_pkg::ZW-1:0] z_in,
    output pcc_pkg::pcc_side_t             side_out,
    output logic signed [XW-1:0]           x_out,
    output logic signed [XW-1:0]           y_out,
    output logic signed [pcc_pkg::ZW-1:0]  z_out
);
    import pcc_pkg::*;

    localparam logic signed [ZW-1:0] ARC = ZW'(ATAN_TABLE[STAGE]);

    pcc_side_t             side_reg;
    logic signed [XW-1:0]  x_reg, x_next;
    logic signed [XW-1:0]  y_reg, y_next;
    logic signed [ZW-1:0]  z_reg, z_next;
    logic signed [XW-1:0]  dx;
    logic signed [XW-1:0]  dy;
    logic                  ccw;

    assign dx  = y_in >>> STAGE;
    assign dy  = x_in >>> STAGE;
    // Rotation chases the residual angle; vectoring drives y toward zero.
    assign ccw = (side_in.opcode == OP_TO_CART) ? !z_in[ZW-1] : y_in[XW-1];

    always_comb begin
        if (ccw) begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ARC;
        end else begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ARC;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg <= '0;
        end else if (en) begin
            side_reg <= side_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign side_out = side_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;

    // In vectoring, x starts non-negative and only grows.
    a_vec_x_nonneg: assert property (@(posedge aclk) disable iff (!aresetn)
        side_reg.valid && (side_reg.opcode == OP_TO_POLAR) |-> !x_reg[XW-1])
        else $error("pcc_cell: negative x during vectoring");

endmodule
`default_nettype wire

### rtl/pcc_post.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcc_post: result formatting and output register
// Stage one rounds the rotated coordinates and the angle and splits the
// magnitude gain product in two; stage two sums it, saturates and holds
// the result until the downstream side takes it.
// ----------------------------------------------------------------------------
module pcc_post #(
    parameter int DW = 16,
    parameter int XW = 34
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      en,
    input  wire pcc_pkg::pcc_side_t        side_in,
    input  wire logic signed [XW-1:0]      x_in,
    input  wire logic signed [XW-1:0]      y_in,
    input  wire logic signed [pcc_pkg::ZW-1:0] z_in,
    input  wire logic                      out_ready,
    output logic                           stall,
    output logic                           out_valid,
    output logic signed [DW-1:0]           out_first,
    output logic signed [DW-1:0]           out_second
);
    import pcc_pkg::*;

    localparam int SH  = 32 - DW;
    localparam int UW  = XW - 1;
    localparam int HW  = UW - 24;
    localparam int QW  = XW - GUARD + 1;
    localparam int MGW = DW + 18;
    localparam logic signed [XW:0]   RND    = (XW+1)'(1) <<< (GUARD - 1);
    localparam logic signed [QW-1:0] Q_MAX  = QW'({1'b0, {(DW-1){1'b1}}});
    localparam logic signed [QW-1:0] Q_MIN  = ~Q_MAX;
    localparam logic [DW-1:0]        SAT_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0]        SAT_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic [MGW:0]         MG_RND = (MGW+1)'(1) << (GUARD - 1);
    localparam logic [QW-1:0]        MAG_MAX = QW'(SAT_MAX);

    function automatic logic signed [DW-1:0] round_sat(input logic signed [XW-1:0] v);
        logic signed [XW:0]   t;
        logic signed [QW-1:0] q;
        t = (XW+1)'(v) + RND;
        q = t[XW:GUARD];
        if (q > Q_MAX) begin
            return SAT_MAX;
        end else if (q < Q_MIN) begin
            return SAT_MIN;
        end
        return DW'(q);
    endfunction

    pcc_side_t              s1_side_reg;
    logic [HW+29:0]         s1_hi_reg, hi_next;
    logic [53:0]            s1_lo_reg, lo_next;
    logic signed [DW-1:0]   s1_r0_reg, r0_next;
    logic signed [DW-1:0]   s1_y_reg;
    logic [UW-1:0]          ux;
    logic [DW-1:0]          angle_next;

    logic                   out_valid_reg;
    logic signed [DW-1:0]   r0_reg;
    logic signed [DW-1:0]   r1_reg, r1_next;
    logic [54:0]            low_sum;
    logic [MGW-1:0]         mg;
    logic [MGW:0]           mg_rnd;
    logic [QW-1:0]          mq;
    logic [DW-1:0]          mag;
    logic                   ld;

    // Negative x after vectoring counts as zero magnitude.
    assign ux      = x_in[XW-1] ? '0 : x_in[UW-1:0];
    assign hi_next = ux[UW-1:24] * GAIN_Q30;
    assign lo_next = ux[23:0] * GAIN_Q30;

    generate
        if (SH == 0) begin : g_angle_full
            assign angle_next = z_in[31:0];
        end else begin : g_angle_round
            localparam logic [31:0] ZRND = 32'(1) << (SH - 1);
            logic [31:0] zr;
            assign zr         = z_in[31:0] + ZRND;
            assign angle_next = zr[31:SH];
        end
    endgenerate

    always_comb begin
        unique case (side_in.opcode)
            OP_TO_CART:  r0_next = round_sat(x_in);
            OP_TO_POLAR: r0_next = side_in.origin ? '0 : angle_next;
            default:     r0_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_side_reg <= '0;
        end else if (en) begin
            s1_side_reg <= side_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_hi_reg <= hi_next;
            s1_lo_reg <= lo_next;
            s1_r0_reg <= r0_next;
            s1_y_reg  <= round_sat(y_in);
        end
    end

    // Exact floor of (hi * 2^24 + lo) / 2^30 without forming the full sum.
    assign low_sum = 55'({s1_hi_reg[5:0], 24'd0}) + 55'(s1_lo_reg);
    assign mg      = MGW'(s1_hi_reg >> 6) + MGW'(low_sum[54:30]);
    assign mg_rnd  = (MGW+1)'(mg) + MG_RND;
    assign mq      = mg_rnd[MGW:GUARD];
    assign mag     = (mq > MAG_MAX) ? SAT_MAX : DW'(mq);

    always_comb begin
        unique case (s1_side_reg.opcode)
            OP_TO_CART:  r1_next = s1_y_reg;
            OP_TO_POLAR: r1_next = s1_side_reg.origin ? '0 : mag;
            default:     r1_next = '0;
        endcase
    end

    assign ld    = !out_valid_reg || out_ready;
    assign stall = s1_side_reg.valid && !ld;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ld) begin
            out_valid_reg <= s1_side_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld) begin
            r0_reg <= s1_r0_reg;
            r1_reg <= r1_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_first  = r0_reg;
    assign out_second = r1_reg;

    // A request waiting in stage one is never dropped while the output is busy.
    a_hold_s1: assert property (@(posedge aclk) disable iff (!aresetn)
        stall |=> s1_side_reg.valid && out_valid_reg)
        else $error("pcc_post: stage one request lost during a stall");

    // A magnitude is never negative after saturation.
    a_mag_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_side_reg.valid && ld && (s1_side_reg.opcode == OP_TO_POLAR)
        |=> !r1_reg[DW-1])
        else $error("pcc_post: negative magnitude");

endmodule
`default_nettype wire

### rtl/polar_cartesian_converter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// polar_cartesian_converter_unit: pipelined CORDIC polar/Cartesian converter
// Opcode 0 turns (angle, radius) into (x, y); opcode 1 turns (x, y) into
// (angle, magnitude). One micro-rotation cell per iteration.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake               Payload
// s_axis    in   s_axis_tvalid/tready    tdata: first_operand, second_operand
//                                        tuser: opcode
// m_axis    out  m_axis_tvalid/tready    tdata: first_result, second_result
//
// One request is taken per cycle while s_axis_tready is high; each result
// passes two setup stages, one cell per iteration, one formatting stage
// and the output register before it appears on m_axis.
// Reset clears the valid bits of every stage; no clearing pass is needed.
// When a result waits in the output register, the pipeline keeps filling
// until a result reaches the stage right before it; only then does the
// whole chain hold and s_axis_tready drop.
// ----------------------------------------------------------------------------
module polar_cartesian_converter_unit #(
    parameter int DATA_WIDTH = 16,
    parameter int ITERATIONS = 16
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    s_axis_tvalid,
    output logic                                         s_axis_tready,
    // first_operand, second_operand, zero fill
    input  wire logic [((2*DATA_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
    // opcode
    input  wire logic                                    s_axis_tuser,
    output logic                                         m_axis_tvalid,
    input  wire logic                                    m_axis_tready,
    // first_result, second_result, zero fill
    output logic [((2*DATA_WIDTH+7)/8)*8-1:0]            m_axis_tdata
);
    import pcc_pkg::*;

    localparam int TDW = ((2*DATA_WIDTH+7)/8)*8;
    localparam int XW  = DATA_WIDTH + GUARD + 2;

    pcc_side_t                    side_chain [ITERATIONS+1];
    logic signed [XW-1:0]         x_chain    [ITERATIONS+1];
    logic signed [XW-1:0]         y_chain    [ITERATIONS+1];
    logic signed [ZW-1:0]         z_chain    [ITERATIONS+1];

    logic                         stall;
    logic                         adv;
    logic signed [DATA_WIDTH-1:0] first_result;
    logic signed [DATA_WIDTH-1:0] second_result;

    assign adv           = !stall;
    assign s_axis_tready = adv;

    pcc_prep #(
        .DW (DATA_WIDTH),
        .XW (XW)
    ) u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s_axis_tvalid),
        .in_opcode (pcc_op_t'(s_axis_tuser)),
        .in_a      (s_axis_tdata[DATA_WIDTH-1:0]),
        .in_b      (s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
        .out_side  (side_chain[0]),
        .out_x     (x_chain[0]),
        .out_y     (y_chain[0]),
        .out_z     (z_chain[0])
    );

    generate
        for (genvar g = 0; g < ITERATIONS; g++) begin : g_cell
            pcc_cell #(
                .XW    (XW),
                .STAGE (g)
            ) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .en       (adv),
                .side_in  (side_chain[g]),
                .x_in     (x_chain[g]),
                .y_in     (y_chain[g]),
                .z_in     (z_chain[g]),
                .side_out (side_chain[g+1]),
                .x_out    (x_chain[g+1]),
                .y_out    (y_chain[g+1]),
                .z_out    (z_chain[g+1])
            );
        end
    endgenerate

    pcc_post #(
        .DW (DATA_WIDTH),
        .XW (XW)
    ) u_post (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (adv),
        .side_in    (side_chain[ITERATIONS]),
        .x_in       (x_chain[ITERATIONS]),
        .y_in       (y_chain[ITERATIONS]),
        .z_in       (z_chain[ITERATIONS]),
        .out_ready  (m_axis_tready),
        .stall      (stall),
        .out_valid  (m_axis_tvalid),
        .out_first  (first_result),
        .out_second (second_result)
    );

    assign m_axis_tdata = TDW'({second_result, first_result});

    // Input is refused only while a finished result is waiting downstream.
    a_ready_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("polar_cartesian_converter_unit: input refused without backpressure");

endmodule
`default_nettype wire
